### design/uhma_pkg.sv
`timescale 1ns / 1ps

package uhma_pkg;

  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned AddrW    = 22;
  localparam int unsigned LenW     = 23;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned BrkW     = 23;
  localparam int unsigned CountW   = 11;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_SET_BRK = 3'd0,
    REQ_RESERVE = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_MAP     = 3'd3,
    REQ_QUERY   = 3'd4,
    REQ_IN_HEAP = 3'd5
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOMEM = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAP_BEGIN  = 2'd0,
    CFG_CODE_FLOOR  = 2'd1,
    CFG_FRAME_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_GROW,
    OP_MAP,
    OP_REL,
    OP_QRY,
    OP_RSV
  } op_e;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

endpackage

### design/uhma_req_if.sv
`timescale 1ns / 1ps

interface uhma_req_if;
  logic                        valid;
  logic                        ready;
  logic [uhma_pkg::ReqTypeW-1:0] req_type;
  logic [uhma_pkg::AddrW-1:0]  addr;
  logic [uhma_pkg::LenW-1:0]   len_or_end;

  modport source (output valid, req_type, addr, len_or_end, input ready);
  modport sink   (input valid, req_type, addr, len_or_end, output ready);
endinterface

### design/uhma_rsp_if.sv
`timescale 1ns / 1ps

interface uhma_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [uhma_pkg::StatusW-1:0] status;
  logic [uhma_pkg::AddrW-1:0]   base_addr;
  logic                         answer;
  logic [uhma_pkg::BrkW-1:0]    brk_now;

  modport source (output valid, status, base_addr, answer, brk_now, input ready);
  modport sink   (input valid, status, base_addr, answer, brk_now, output ready);
endinterface

### design/uhma_ram.sv
`timescale 1ns / 1ps

module uhma_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/user_heap_and_mmap_page_allocator.sv
`timescale 1ns / 1ps
// Page allocator with program break; one result per transaction, one in flight.
// Requests that touch no page go straight to the output state; else each page
// visited takes a bitmap read state and an evaluate/write-back state, and a
// reserve may rescan after a jump. A new transaction is taken only once the last
// result is registered; a held result stalls the next. Reset: control state
// clears, then a clearing pass zeroes the page bitmap; no request is accepted until it ends.
module user_heap_and_mmap_page_allocator #(
  parameter int unsigned PAGE_BITS = 12,
  parameter int unsigned NUM_PAGES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  uhma_req_if.sink                      req_i,
  uhma_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [uhma_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [uhma_pkg::AddrW-1:0]    cfg_data_i
);

  // Byte width covers the space top, the 23-bit range end and a carry.
  localparam int unsigned IW  = $clog2(NUM_PAGES);
  localparam int unsigned SPW = PAGE_BITS + IW;
  localparam int unsigned BW  = (SPW + 1 > 24) ? SPW + 1 : 24;
  localparam int unsigned PW  = BW - PAGE_BITS;
  localparam logic [BW-1:0] PgLow    = BW'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [BW-1:0] SpaceTop = BW'(64'(NUM_PAGES) << PAGE_BITS);
  localparam logic [PW-1:0] NumPg    = PW'(NUM_PAGES);
  localparam logic [IW-1:0] LastIdx  = IW'(NUM_PAGES - 1);

  function automatic logic [PW-1:0] pg_ceil(input logic [BW-1:0] a);
    logic [BW-1:0] s;
    s = a + PgLow;
    return PW'(s >> PAGE_BITS);
  endfunction

  function automatic logic [PW-1:0] pg_floor(input logic [BW-1:0] a);
    return PW'(a >> PAGE_BITS);
  endfunction

  function automatic logic [BW-1:0] pg_addr(input logic [PW-1:0] p);
    return BW'(p) << PAGE_BITS;
  endfunction

  uhma_pkg::state_e state_q, state_d;
  uhma_pkg::op_e    op_q, op_d;

  logic [uhma_pkg::AddrW-1:0]  heap_q, heap_d, floor_cfg_q, floor_cfg_d;
  logic [uhma_pkg::CountW-1:0] limit_q, limit_d, cnt_q, cnt_d;
  logic [uhma_pkg::BrkW-1:0]   brk_q, brk_d;
  logic [IW-1:0]               clr_q, clr_d;

  logic [PW-1:0] pg_q, pg_d, last_q, last_d, occ_q, occ_d;
  logic          hit_q, hit_d, brk_set_q, brk_set_d;
  logic [BW-1:0] nb_q, nb_d, span_q, span_d, flr_q, flr_d, base_q, base_d;

  logic [uhma_pkg::StatusW-1:0] st_q, st_d;
  logic                         ans_q, ans_d;

  logic                         ov_q, ov_d;
  logic [uhma_pkg::StatusW-1:0] o_st_q, o_st_d;
  logic [uhma_pkg::AddrW-1:0]   o_base_q, o_base_d;
  logic                         o_ans_q, o_ans_d;
  logic [uhma_pkg::BrkW-1:0]    o_brk_q, o_brk_d;

  logic          ram_we, ram_wdata, ram_rdata;
  logic [IW-1:0] ram_waddr;

  logic [BW-1:0] cb, in_addr, in_len, rsv_floor, rsv_fl_raw, occ_b, nbase;
  logic          req_fire;

  uhma_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pg_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Break of zero reads as heap start.
  assign cb       = (brk_q == '0) ? BW'(heap_q) : BW'(brk_q);
  assign in_addr  = BW'(req_i.addr);
  assign in_len   = BW'(req_i.len_or_end);
  assign rsv_fl_raw = pg_addr(pg_ceil(cb));
  assign rsv_floor  = (rsv_fl_raw < BW'(floor_cfg_q)) ? BW'(floor_cfg_q) : rsv_fl_raw;
  assign occ_b    = pg_addr(occ_q);
  assign nbase    = occ_b - span_q;

  assign req_i.ready = (state_q == uhma_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign rsp_o.valid     = ov_q;
  assign rsp_o.status    = o_st_q;
  assign rsp_o.base_addr = o_base_q;
  assign rsp_o.answer    = o_ans_q;
  assign rsp_o.brk_now   = o_brk_q;

  always_comb begin
    state_d = state_q;  op_d = op_q;
    heap_d = heap_q;  floor_cfg_d = floor_cfg_q;  limit_d = limit_q;
    cnt_d = cnt_q;  brk_d = brk_q;  clr_d = clr_q;
    pg_d = pg_q;  last_d = last_q;  occ_d = occ_q;  hit_d = hit_q;
    brk_set_d = brk_set_q;  nb_d = nb_q;  span_d = span_q;  flr_d = flr_q;
    base_d = base_q;  st_d = st_q;  ans_d = ans_q;
    ov_d = ov_q;  o_st_d = o_st_q;  o_base_d = o_base_q;
    o_ans_d = o_ans_q;  o_brk_d = o_brk_q;
    ram_we = 1'b0;  ram_wdata = 1'b0;  ram_waddr = pg_q[IW-1:0];

    if (cfg_we_i) begin
      case (cfg_idx_i)
        uhma_pkg::CFG_HEAP_BEGIN:  heap_d      = cfg_data_i;
        uhma_pkg::CFG_CODE_FLOOR:  floor_cfg_d = cfg_data_i;
        uhma_pkg::CFG_FRAME_LIMIT: limit_d     = cfg_data_i[uhma_pkg::CountW-1:0];
        default: ;
      endcase
    end

    // Drop the result once the sink takes it.
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      uhma_pkg::S_CLR: begin
        // Sweep the bitmap to zero after reset.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
        if (clr_q == LastIdx) begin
          state_d = uhma_pkg::S_IDLE;
        end
      end

      uhma_pkg::S_IDLE: begin
        if (req_fire) begin
          st_d      = uhma_pkg::ST_OK;
          ans_d     = 1'b0;
          base_d    = '0;
          hit_d     = 1'b0;
          brk_set_d = 1'b0;
          nb_d      = in_addr;
          state_d   = uhma_pkg::S_OUT;
          case (req_i.req_type)
            uhma_pkg::REQ_SET_BRK: begin
              if (heap_q == '0 || in_addr < BW'(heap_q)) begin
                st_d = uhma_pkg::ST_INVAL;
              end else if (in_addr > cb) begin
                op_d    = uhma_pkg::OP_GROW;
                pg_d    = pg_floor(cb);
                last_d  = pg_ceil(in_addr);
                state_d = uhma_pkg::S_RD;
              end else if (in_addr < cb) begin
                op_d      = uhma_pkg::OP_REL;
                brk_set_d = 1'b1;
                pg_d      = pg_ceil(in_addr);
                last_d    = NumPg;
                state_d   = uhma_pkg::S_RD;
              end
            end
            uhma_pkg::REQ_RESERVE: begin
              span_d = in_len;
              flr_d  = rsv_floor;
              if (in_len == '0 || (in_len & PgLow) != '0) begin
                st_d = uhma_pkg::ST_INVAL;
              end else if (in_len > SpaceTop || (SpaceTop - in_len) < rsv_floor) begin
                st_d = uhma_pkg::ST_NOMEM;
              end else begin
                op_d    = uhma_pkg::OP_RSV;
                base_d  = SpaceTop - in_len;
                pg_d    = pg_floor(SpaceTop - in_len);
                last_d  = NumPg;
                state_d = uhma_pkg::S_RD;
              end
            end
            uhma_pkg::REQ_RELEASE: begin
              op_d    = uhma_pkg::OP_REL;
              pg_d    = pg_ceil(in_addr);
              last_d  = NumPg;
              state_d = uhma_pkg::S_RD;
            end
            uhma_pkg::REQ_MAP: begin
              if (pg_floor(in_addr) >= NumPg) begin
                st_d = uhma_pkg::ST_INVAL;
              end else begin
                op_d    = uhma_pkg::OP_MAP;
                pg_d    = pg_floor(in_addr);
                last_d  = pg_floor(in_addr) + PW'(1);
                state_d = uhma_pkg::S_RD;
              end
            end
            uhma_pkg::REQ_QUERY: begin
              if (in_addr >= in_len) begin
                ans_d = 1'b1;
              end else begin
                op_d    = uhma_pkg::OP_QRY;
                pg_d    = pg_floor(in_addr);
                last_d  = (pg_ceil(in_len) > NumPg) ? NumPg : pg_ceil(in_len);
                state_d = uhma_pkg::S_RD;
              end
            end
            uhma_pkg::REQ_IN_HEAP: begin
              ans_d = (heap_q != '0) && (in_addr >= BW'(heap_q)) && (in_addr < cb);
            end
            default: st_d = uhma_pkg::ST_INVAL;
          endcase
        end
      end

      uhma_pkg::S_RD: begin
        // Close the walk at the window end, fail a grow that runs past the last page, else issue the bitmap read.
        state_d = uhma_pkg::S_EV;
        if (pg_q >= last_q) begin
          state_d = uhma_pkg::S_OUT;
          case (op_q)
            uhma_pkg::OP_GROW: brk_d = uhma_pkg::BrkW'(nb_q);
            uhma_pkg::OP_REL: begin
              if (brk_set_q) begin
                brk_d = uhma_pkg::BrkW'(nb_q);
              end
            end
            uhma_pkg::OP_QRY: ans_d = 1'b1;
            uhma_pkg::OP_RSV: begin
              if (hit_q) begin
                // Jump below the highest occupied page and rescan.
                if (occ_b < span_q || nbase < flr_q) begin
                  st_d   = uhma_pkg::ST_NOMEM;
                  base_d = '0;
                end else begin
                  base_d  = nbase;
                  pg_d    = pg_floor(nbase);
                  last_d  = pg_floor(nbase) + pg_floor(span_q);
                  hit_d   = 1'b0;
                  state_d = uhma_pkg::S_RD;
                end
              end
            end
            default: ;
          endcase
        end else if (op_q == uhma_pkg::OP_GROW && pg_q >= NumPg) begin
          st_d    = uhma_pkg::ST_NOMEM;
          state_d = uhma_pkg::S_OUT;
        end
      end

      uhma_pkg::S_EV: begin
        pg_d    = pg_q + PW'(1);
        state_d = uhma_pkg::S_RD;
        case (op_q)
          uhma_pkg::OP_GROW, uhma_pkg::OP_MAP: begin
            if (!ram_rdata) begin
              if (cnt_q >= limit_q) begin
                st_d    = uhma_pkg::ST_NOMEM;
                state_d = uhma_pkg::S_OUT;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                cnt_d     = cnt_q + uhma_pkg::CountW'(1);
              end
            end
          end
          uhma_pkg::OP_REL: begin
            if (ram_rdata) begin
              ram_we = 1'b1;
              if (cnt_q != '0) begin
                cnt_d = cnt_q - uhma_pkg::CountW'(1);
              end
            end
          end
          uhma_pkg::OP_QRY: begin
            if (ram_rdata) begin
              state_d = uhma_pkg::S_OUT;
            end
          end
          uhma_pkg::OP_RSV: begin
            if (ram_rdata) begin
              hit_d = 1'b1;
              occ_d = pg_q;
            end
          end
          default: ;
        endcase
      end

      uhma_pkg::S_OUT: begin
        // Hold until the output register is free.
        if (!ov_q || rsp_o.ready) begin
          ov_d     = 1'b1;
          o_st_d   = st_q;
          o_base_d = uhma_pkg::AddrW'(base_q);
          o_ans_d  = ans_q;
          o_brk_d  = uhma_pkg::BrkW'(cb);
          state_d  = uhma_pkg::S_IDLE;
        end
      end

      default: state_d = uhma_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uhma_pkg::S_CLR;
      heap_q      <= '0;
      floor_cfg_q <= uhma_pkg::AddrW'(65536);
      limit_q     <= uhma_pkg::CountW'(1024);
      cnt_q       <= '0;
      brk_q       <= '0;
      clr_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_q      <= heap_d;
      floor_cfg_q <= floor_cfg_d;
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      brk_q       <= brk_d;
      clr_q       <= clr_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pg_q      <= pg_d;
    last_q    <= last_d;
    occ_q     <= occ_d;
    hit_q     <= hit_d;
    brk_set_q <= brk_set_d;
    nb_q      <= nb_d;
    span_q    <= span_d;
    flr_q     <= flr_d;
    base_q    <= base_d;
    st_q      <= st_d;
    ans_q     <= ans_d;
    o_st_q    <= o_st_d;
    o_base_q  <= o_base_d;
    o_ans_q   <= o_ans_d;
    o_brk_q   <= o_brk_d;
  end

endmodule
